// ===== hw/rtl/crf_pkg.sv =====
// Shared types and constants for the closable ring FIFO.
// No dependencies; imported by closable_ring_fifo.
package crf_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;   // fill level and capacity register width
    localparam int CAP_RST  = 16;  // capacity register value after reset, clamped to DEPTH

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_WAIT = 3'd0,
        ACT_PUSH_TRY  = 3'd1,
        ACT_POP       = 3'd2,
        ACT_CLOSE     = 3'd3,
        ACT_CANCEL    = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_CLOSED   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_WAIT     = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/crf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used as the entry store of closable_ring_fifo.
module crf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/closable_ring_fifo.sv =====
// Top level of the closable ring FIFO: control, status and stream ports.
// Depends on crf_pkg (types, codes) and crf_ram (entry store).

// Bounded ring FIFO with close and cancel. Each item on the slave stream
// carries one action (waiting push, try push, pop, close, cancel) and yields
// exactly one result item: a status, the popped word (zero unless a pop
// succeeded) and the fill level after the action. Blocking is never done in
// hardware: a waiting push into a full open queue or a pop from an empty open
// queue answers "would wait" and the source retries; a try push into a full
// open queue answers "overflow". After close, pushes answer "closed" while
// pops still drain the words held; cancel closes and empties the queue. The
// block takes one item per clock unless stalled (result held or realigning):
// the decision is made from the state registers in the cycle of acceptance
// and the result appears in the output register in the next cycle, with the
// popped word coming from the registered read port of the entry RAM. A new
// item is accepted in the same cycle the previous result is taken. The
// capacity register (0 acts as 1, anything above DEPTH as DEPTH) may be
// written only while the block is idle; after a write the block realigns the
// head index to the new capacity, one subtraction per cycle, and holds
// s_tready low then. Entry contents are not cleared by reset.
module closable_ring_fifo
    import crf_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // slave stream: action [2:0], push_data [3 +: DATA_WIDTH], zero pad
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    input  logic [((ACTION_W+DATA_WIDTH+7)/8)*8-1:0]  i_s_tdata,
    // master stream: status [1:0], pop_data [2 +: DATA_WIDTH],
    // fill_level [2+DATA_WIDTH +: 5], zero pad
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [((STATUS_W+DATA_WIDTH+CNT_W+7)/8)*8-1:0] o_m_tdata,
    // capacity register write channel
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [CNT_W-1:0]                          i_cfg_data
);

    localparam int OUT_W  = ((STATUS_W + DATA_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // sum width for head + count and the compares against capacity
    localparam int SW     = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int CAP_R  = (DEPTH < CAP_RST) ? DEPTH : CAP_RST;

    // state
    logic [AW-1:0]         r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_closed, n_closed;
    logic [CNT_W-1:0]      r_cap;       // effective capacity, already clamped
    logic                  r_norm;      // head realignment after capacity write

    // result register
    logic                  r_out_valid;
    t_status               r_status, n_status;
    logic                  r_pop_ok, n_pop_ok;
    logic [CNT_W-1:0]      r_fill;

    // datapath
    t_action               w_action;
    logic [DATA_WIDTH-1:0] w_push_data;
    logic                  w_accept;
    logic                  w_cfg_we;
    logic [CNT_W-1:0]      w_cap_clamp;
    logic [SW-1:0]         w_head_x, w_cap_x, w_sum, w_tail, w_head_inc;
    logic                  w_full;
    logic                  w_we;
    logic                  w_re;
    logic [DATA_WIDTH-1:0] w_rdata;

    assign w_action    = t_action'(i_s_tdata[ACTION_W-1:0]);
    assign w_push_data = i_s_tdata[ACTION_W +: DATA_WIDTH];

    // Hold the slave side while the result slot is occupied and not drained,
    // and while the head index is being realigned.
    assign o_s_tready  = !r_norm && (!r_out_valid || i_m_tready);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Clamp the written capacity into 1..DEPTH.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cap_clamp = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(DEPTH)) begin
            w_cap_clamp = CNT_W'(DEPTH);
        end else begin
            w_cap_clamp = i_cfg_data;
        end
    end

    assign w_head_x   = SW'(r_head);
    assign w_cap_x    = SW'(r_cap);
    assign w_full     = r_count >= r_cap;
    // Head stays below capacity, and a push only happens below capacity, so
    // one conditional subtract wraps the tail.
    assign w_sum      = w_head_x + SW'(r_count);
    assign w_tail     = (w_sum >= w_cap_x) ? (w_sum - w_cap_x) : w_sum;
    assign w_head_inc = w_head_x + SW'(1);

    // Action decode: status, state update and RAM strobes.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_closed = r_closed;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;

        if (r_norm) begin
            // Realign: drop whole capacities from the head, one per cycle.
            if (w_head_x >= w_cap_x) begin
                n_head = AW'(w_head_x - w_cap_x);
            end
        end else if (w_accept) begin
            unique case (w_action)
                ACT_PUSH_WAIT, ACT_PUSH_TRY: begin
                    if (r_closed) begin
                        n_status = ST_CLOSED;
                    end else if (w_full) begin
                        n_status = (w_action == ACT_PUSH_WAIT) ? ST_WAIT : ST_OVERFLOW;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_POP: begin
                    if (r_count == '0) begin
                        n_status = r_closed ? ST_CLOSED : ST_WAIT;
                    end else begin
                        w_re     = 1'b1;
                        n_pop_ok = 1'b1;
                        n_head   = (w_head_inc == w_cap_x) ? '0 : AW'(w_head_inc);
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                ACT_CLOSE: begin
                    n_closed = 1'b1;
                end
                ACT_CANCEL: begin
                    n_closed = 1'b1;
                    n_count  = '0;
                    n_head   = '0;
                end
                default: begin
                    // unused codes: no state change, status ok
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_closed    <= 1'b0;
            r_cap       <= CNT_W'(CAP_R);
            r_norm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_closed <= n_closed;
            if (w_cfg_we) begin
                r_cap  <= w_cap_clamp;
                r_norm <= 1'b1;
            end else if (r_norm && (w_head_x < w_cap_x)) begin
                r_norm <= 1'b0;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; advance only on acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
            r_fill   <= n_count;
        end
    end

    // Entry store. The read port is strobed only by an accepted pop, so its
    // data holds while the result waits.
    crf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tail[AW-1:0]),
        .i_wdata (w_push_data),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_fill, (r_pop_ok ? w_rdata : {DATA_WIDTH{1'b0}}), r_status});

`ifndef NO_ASSERTIONS
    // Head index lies inside the ring whenever items are being taken.
    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_norm |-> (w_head_x < w_cap_x))
        else $error("head index outside the ring");

    // A successful pop removes exactly one entry.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == ACT_POP && r_count != '0)
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement the entry count");

    // Cancel leaves the queue closed and empty.
    a_cancel_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == ACT_CANCEL) |=> (r_closed && r_count == '0 && r_head == '0))
        else $error("cancel did not close and flush");

    // A popped word is reported only with status ok.
    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pop_ok) |-> (r_status == ST_OK))
        else $error("pop data with failing status");
`endif

endmodule

// ===== tb/sv/closable_ring_fifo_tb.sv =====
// Self-checking testbench for the closable ring FIFO: directed and random actions,
// with a predictor of the ring state. Depends on crf_pkg and closable_ring_fifo.
`timescale 1ns / 1ps

module closable_ring_fifo_tb;
    import crf_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int S_TDATA_W   = ((ACTION_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((STATUS_W + DATA_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;   // long receiver stall in the pressure test
    localparam int END_CYCLES  = 40;    // covers the head realignment after a capacity write
    localparam int MAX_REPORTS = 50;

    // action codes the block ignores
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

    typedef struct {
        t_status               status;
        logic [DATA_WIDTH-1:0] pop_data;
        logic [CNT_W-1:0]      fill_level;
    } t_fifo_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data  = '0;

    // ring state as the block should hold it
    logic [DATA_WIDTH-1:0] ring_store [DEPTH];
    logic [DEPTH-1:0]      ring_written = '0;
    int unsigned           ring_head    = 0;
    int unsigned           ring_count   = 0;
    bit                    ring_closed  = 1'b0;
    logic [CNT_W-1:0]      capacity_reg = CAP_RST[CNT_W-1:0];

    t_fifo_result pending_results[$];

    int  err_count    = 0;
    int  cycle_count  = 0;
    int  snd_idle_pct = 24;
    int  rcv_idle_pct = 45;
    int  hold_req     = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;
    bit  offering     = 1'b0;

    closable_ring_fifo #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold whenever one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                   logic [DATA_WIDTH-1:0] want);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
        err_count++;
    endtask

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_fifo_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_m_tdata[DATA_WIDTH-1:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[STATUS_W-1:0] != want.status)
                    report_mismatch("status", DATA_WIDTH'(o_m_tdata[STATUS_W-1:0]),
                                    DATA_WIDTH'(want.status));
                if (o_m_tdata[STATUS_W +: DATA_WIDTH] != want.pop_data)
                    report_mismatch("pop_data", o_m_tdata[STATUS_W +: DATA_WIDTH],
                                    want.pop_data);
                if (o_m_tdata[STATUS_W + DATA_WIDTH +: CNT_W] != want.fill_level)
                    report_mismatch("fill_level",
                                    DATA_WIDTH'(o_m_tdata[STATUS_W + DATA_WIDTH +: CNT_W]),
                                    DATA_WIDTH'(want.fill_level));
            end
        end
    end

    function automatic int unsigned ring_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > DEPTH)
            return DEPTH;
        return capacity_reg;
    endfunction

    // apply one action to the ring state and queue the result it must give
    function automatic void apply_action(logic [ACTION_W-1:0] act,
                                         logic [DATA_WIDTH-1:0] word);
        t_fifo_result res;
        int unsigned  cap;
        int unsigned  tail;
        cap          = ring_capacity();
        res.status   = ST_OK;
        res.pop_data = '0;
        case (act)
            ACT_PUSH_WAIT, ACT_PUSH_TRY: begin
                if (ring_closed) begin
                    res.status = ST_CLOSED;
                end else if (ring_count >= cap) begin
                    res.status = (act == ACT_PUSH_WAIT) ? ST_WAIT : ST_OVERFLOW;
                end else begin
                    tail               = (ring_head + ring_count) % cap;
                    ring_store[tail]   = word;
                    ring_written[tail] = 1'b1;
                    ring_count++;
                end
            end
            ACT_POP: begin
                if (ring_count == 0) begin
                    res.status = ring_closed ? ST_CLOSED : ST_WAIT;
                end else begin
                    res.pop_data = ring_store[ring_head % cap];
                    ring_head    = (ring_head + 1) % cap;
                    ring_count--;
                end
            end
            ACT_CLOSE: ring_closed = 1'b1;
            ACT_CANCEL: begin
                ring_closed = 1'b1;
                ring_count  = 0;
                ring_head   = 0;
            end
            default: ;
        endcase
        res.fill_level = ring_count[CNT_W-1:0];
        pending_results.push_back(res);
    endfunction

    // offer one item after a random gap, hold it until accepted, then predict
    task automatic send_item(logic [ACTION_W-1:0] act, logic [DATA_WIDTH-1:0] word);
        logic [S_TDATA_W-1:0] beat;
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < snd_idle_pct)
            gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            offering    = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat                      = '0;
        beat[ACTION_W-1:0]        = act;
        beat[ACTION_W +: DATA_WIDTH] = word;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        offering    = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        apply_action(act, word);
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_until_idle();
        if (offering) begin
            i_s_tvalid <= 1'b0;
            offering    = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain_ring();
        while (ring_count != 0)
            send_item(ACT_POP, random_word());
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] value);
        // a resize with words held may bring a never-written entry to the head
        if (!(&ring_written))
            drain_ring();
        wait_until_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_reg = value;
    endtask

    function automatic logic [CNT_W-1:0] random_capacity();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return CNT_W'(DEPTH);
            3:       return CNT_W'($urandom_range(DEPTH + 1, 31));
            default: return CNT_W'($urandom_range(2, DEPTH - 1));
        endcase
    endfunction

    // push-heavy or pop-heavy mix so that both full and empty are reached
    function automatic logic [ACTION_W-1:0] random_open_action(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? ACT_PUSH_TRY : ACT_PUSH_WAIT;
        return ACT_POP;
    endfunction

    task automatic test_single_slot();
        set_capacity(1);
        send_item(ACT_PUSH_WAIT, '1);
        send_item(ACT_PUSH_WAIT, 32'h1234_5678);    // full: would wait
        send_item(ACT_PUSH_TRY, 32'h8765_4321);     // full: overflow
        send_item(ACT_POP, '0);
        send_item(ACT_POP, '0);                     // empty and open: would wait
        send_item(ACT_PUSH_TRY, '0);
        send_item(ACT_SPARE_LO, '1);
        send_item(ACT_SPARE_HI, 32'hA5A5_5A5A);
        send_item(ACT_POP, '1);
        // zero capacity behaves as one slot
        set_capacity(0);
        send_item(ACT_PUSH_TRY, 32'h5A5A_A5A5);
        send_item(ACT_PUSH_TRY, 32'hFFFF_0000);
        send_item(ACT_POP, '0);
        wait_until_idle();
    endtask

    task automatic run_random_phase(int n_items, int snd_pct, int rcv_pct);
        int seg;
        int push_pct;
        snd_idle_pct  = snd_pct;
        rcv_idle_pct <= rcv_pct;
        while (n_items > 0) begin
            seg      = $urandom_range(12, 60);
            push_pct = $urandom_range(15, 85);
            repeat (seg)
                send_item(random_open_action(push_pct), random_word());
            n_items -= seg;
            if ($urandom_range(0, 3) == 0)
                set_capacity(random_capacity());
        end
        wait_until_idle();
    endtask

    // hold the receiver off while the sender keeps offering; input must stall
    task automatic test_receiver_hold();
        set_capacity(CNT_W'(DEPTH));
        snd_idle_pct  = 0;
        rcv_idle_pct <= 0;
        hold_req     <= hold_req + 1;
        repeat (40)
            send_item(random_open_action(70), random_word());
        wait_until_idle();
    endtask

    task automatic test_close_and_cancel();
        drain_ring();
        set_capacity(2);
        send_item(ACT_PUSH_WAIT, 32'hC0DE_0001);
        send_item(ACT_PUSH_TRY, 32'hC0DE_0002);
        send_item(ACT_PUSH_TRY, 32'hC0DE_0003);     // full: overflow
        send_item(ACT_PUSH_WAIT, 32'hC0DE_0004);    // full: would wait
        send_item(ACT_CLOSE, '0);
        send_item(ACT_PUSH_TRY, '1);                // closed wins over full
        send_item(ACT_PUSH_WAIT, '1);
        send_item(ACT_POP, '0);                     // pops still drain after close
        send_item(ACT_CANCEL, '0);                  // drop the word still held
        send_item(ACT_POP, '0);                     // empty and closed
        send_item(ACT_CLOSE, '1);
        send_item(ACT_CANCEL, '1);
        send_item(ACT_SPARE_MID, '0);
        send_item(ACT_PUSH_WAIT, '0);
        set_capacity(31);
        repeat (30)
            send_item(ACTION_W'($urandom_range(0, 7)), random_word());
        wait_until_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_slot();
        run_random_phase(500, 24, 45);
        run_random_phase(500, 45, 24);
        run_random_phase(500, 0, 0);
        test_receiver_hold();
        test_close_and_cancel();

        repeat (END_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
